### design/cqpu_pkg.sv
// shared types and constants for the circular queue push/pop unit
package cqpu_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int SIZE_W     = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(DEPTH);

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic               func;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic load;  // capture request and read front slot
    logic exec;  // apply operation and load result register
  } dp_cmd_t;

endpackage

### design/cqpu_ctrl.sv
// controller state machine: sequences capture, execute and result handoff
module cqpu_ctrl
  import cqpu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### design/cqpu_dp.sv
// datapath: slot memory, head/tail pointers, empty flag, size register, result register
module cqpu_dp
  import cqpu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  in_item_t          in_item,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data,
  output out_item_t         out_item
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [SIZE_W-1:0]     size_r;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [IDX_W-1:0]      tail_r, tail_nxt;
  logic                  empty_r, empty_nxt;
  in_item_t              req_r;
  logic [DATA_WIDTH-1:0] rd_data_r;
  out_item_t             out_r, out_nxt;

  logic [IDX_W-1:0]      last_idx;
  logic [IDX_W-1:0]      tail_next_idx;
  logic [IDX_W-1:0]      head_next_idx;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;

  // last usable slot: size 0 acts as 1, anything above the ring acts as the full ring
  always_comb begin
    if (size_r == '0) begin
      last_idx = '0;
    end else if (size_r > SIZE_W'(DEPTH)) begin
      last_idx = IDX_W'(DEPTH - 1);
    end else begin
      last_idx = IDX_W'(size_r - SIZE_W'(1));
    end
  end

  assign tail_next_idx = (tail_r >= last_idx) ? '0 : tail_r + IDX_W'(1);
  assign head_next_idx = (head_r >= last_idx) ? '0 : head_r + IDX_W'(1);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    out_nxt   = out_r;
    wr_en     = 1'b0;
    wr_addr   = tail_next_idx;
    if (cmd.exec) begin
      out_nxt.pop_value = '0;
      out_nxt.status    = STAT_OK;
      if (req_r.func == FUNC_PUSH) begin
        if (empty_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b0;
          wr_en     = 1'b1;
          wr_addr   = '0;
        end else if (tail_next_idx == head_r) begin
          out_nxt.status = STAT_OVERFLOW;
        end else begin
          tail_nxt = tail_next_idx;
          wr_en    = 1'b1;
        end
      end else begin
        if (empty_r) begin
          out_nxt.pop_value = -32'sd1;
          out_nxt.status    = STAT_UNDERFLOW;
        end else begin
          out_nxt.pop_value = 32'(signed'(rd_data_r));
          if (head_r == tail_r) begin
            empty_nxt = 1'b1;
            head_nxt  = '0;
            tail_nxt  = '0;
          end else begin
            head_nxt = head_next_idx;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= SIZE_RESET;
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_data;
      end
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (cmd.load) begin
      req_r     <= in_item;
      rd_data_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= DATA_WIDTH'(req_r.push_value);
    end
  end

  assign out_item = out_r;

endmodule

### design/circular_queue_push_pop_unit.sv
// circular fifo queue: each request is a push or a pop and yields one result
// a request is captured in ST_IDLE, applied in ST_EXEC, and its result is held valid
//   in ST_DONE until taken; a new request is accepted only after the result is taken,
//   as the controller runs the sequence capture/read, execute, result handoff
// reset (rst_n low, synchronous): queue empty, pointers at slot 0, size 16;
//   slot contents are not cleared
module circular_queue_push_pop_unit
  import cqpu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  cqpu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cqpu_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .out_item (out_item)
  );

endmodule

### test/tb_circular_queue_push_pop_unit.sv
// self-checking testbench for the circular queue push/pop unit
module tb_circular_queue_push_pop_unit
  import cqpu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_item   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data  = '0;

  circular_queue_push_pop_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the queue
  logic [DATA_WIDTH-1:0] q_slot [DEPTH];
  int                    q_head  = 0;
  int                    q_tail  = 0;
  logic                  q_empty = 1'b1;
  logic [SIZE_W-1:0]     q_size  = SIZE_RESET;

  in_item_t  pending_ops [$];
  out_item_t results_due [$];

  int err_count      = 0;
  int push_count     = 0;
  int pop_count      = 0;
  int overflow_count = 0;
  int underflow_count = 0;
  int size_writes    = 0;

  function automatic int ring_next(input int idx);
    int n;
    n = (q_size == 0) ? 1 : ((q_size > DEPTH) ? DEPTH : int'(q_size));
    return (idx >= n - 1) ? 0 : idx + 1;
  endfunction

  function automatic out_item_t apply_queue_op(input in_item_t op);
    out_item_t res;
    res.pop_value = '0;
    res.status    = STAT_OK;
    if (op.func == FUNC_PUSH) begin
      if (q_empty) begin
        q_head    = 0;
        q_tail    = 0;
        q_slot[0] = op.push_value;
        q_empty   = 1'b0;
      end else if (ring_next(q_tail) == q_head) begin
        res.status = STAT_OVERFLOW;
      end else begin
        q_tail         = ring_next(q_tail);
        q_slot[q_tail] = op.push_value;
      end
    end else begin
      if (q_empty) begin
        res.pop_value = -32'sd1;
        res.status    = STAT_UNDERFLOW;
      end else begin
        res.pop_value = q_slot[q_head];
        if (q_head == q_tail) begin
          q_empty = 1'b1;
          q_head  = 0;
          q_tail  = 0;
        end else begin
          q_head = ring_next(q_head);
        end
      end
    end
    return res;
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("mismatch: %s", msg);
  endtask

  // driver: bursts of requests separated by random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    out_item_t res;
    logic      send;
    send = in_valid;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        res = apply_queue_op(in_item);
        results_due.push_back(res);
        if (in_item.func == FUNC_PUSH) push_count++;
        else pop_count++;
        if (res.status == STAT_OVERFLOW) overflow_count++;
        if (res.status == STAT_UNDERFLOW) underflow_count++;
        send = 1'b0;
      end
      if (!send) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          in_item <= pending_ops.pop_front();
          send = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9)) inside
              0:       gap_left = $urandom_range(10, 40);
              1, 2, 3: gap_left = 0;
              default: gap_left = $urandom_range(1, 4);
            endcase
          end else begin
            burst_left--;
          end
        end
      end
    end
    in_valid <= send;
  end

  // monitor: compare each taken result, stall on a changing pattern
  int stall_mode = 0;
  int mode_left  = 0;
  int stall_tick = 0;

  always @(posedge clk) begin
    out_item_t want;
    logic      nxt_stall;
    nxt_stall = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          flag_error($sformatf("result with none expected: pop_value %0d status %0d",
                               out_item.pop_value, out_item.status));
        end else begin
          want = results_due.pop_front();
          if (out_item.pop_value !== want.pop_value)
            flag_error($sformatf("pop_value expected %0d (%h) actual %0d (%h)",
                                 want.pop_value, want.pop_value,
                                 out_item.pop_value, out_item.pop_value));
          if (out_item.status !== want.status)
            flag_error($sformatf("status expected %0d actual %0d",
                                 want.status, out_item.status));
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(30, 200);
      end else begin
        mode_left--;
      end
      stall_tick++;
      case (stall_mode)
        1:       nxt_stall = ($urandom_range(0, 3) == 0);
        2:       nxt_stall = ($urandom_range(0, 3) != 0);
        3:       nxt_stall = ((stall_tick % 5) < 3);
        default: nxt_stall = 1'b0;
      endcase
    end
    out_stall <= nxt_stall;
  end

  task automatic add_op(input logic f, input logic [31:0] v);
    in_item_t op;
    op.func       = f;
    op.push_value = v;
    pending_ops.push_back(op);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_valid || results_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] sz);
    wait_drained();
    @(posedge clk);
    cfg_data  <= sz;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    q_size = sz;
    cfg_valid <= 1'b0;
    size_writes++;
  endtask

  // segments lean toward filling, draining or a mix so full and empty both occur
  task automatic queue_traffic(input int n_ops);
    int seg;
    int push_pct;
    while (n_ops > 0) begin
      seg = $urandom_range(3, 40);
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      repeat (seg)
        add_op(($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP, pick_value());
      n_ops -= seg;
    end
  endtask

  logic [SIZE_W-1:0] size_plan [12] = '{5'd1, 5'd31, 5'd2, 5'd17, 5'd0, 5'd15,
                                        5'd16, 5'd3, 5'd8, 5'd1, 5'd12, 5'd16};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // at reset size: underflow, then fill all slots so none is ever read unwritten
    add_op(FUNC_POP, 32'h1234_5678);
    add_op(FUNC_PUSH, 32'h8000_0000);
    add_op(FUNC_PUSH, 32'h7fff_ffff);
    add_op(FUNC_PUSH, 32'hffff_ffff);
    add_op(FUNC_PUSH, 32'h0000_0000);
    add_op(FUNC_PUSH, 32'haaaa_aaaa);
    add_op(FUNC_PUSH, 32'h5555_5555);
    repeat (10) add_op(FUNC_PUSH, $urandom);
    add_op(FUNC_PUSH, 32'hdead_beef);
    add_op(FUNC_POP, 32'hffff_ffff);
    add_op(FUNC_POP, 32'h0000_0000);
    add_op(FUNC_PUSH, $urandom);
    add_op(FUNC_PUSH, $urandom);

    // shrink to the smallest size while the queue is full: indices past the end wrap
    write_size(5'd0);
    add_op(FUNC_POP, $urandom);
    add_op(FUNC_PUSH, $urandom);
    add_op(FUNC_POP, $urandom);
    add_op(FUNC_POP, $urandom);

    foreach (size_plan[i]) begin
      write_size(size_plan[i]);
      queue_traffic(88);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d pushes (%0d overflow) and %0d pops (%0d underflow)",
             push_count, overflow_count, pop_count, underflow_count);
    $display("across %0d queue size writes, %0d mismatches", size_writes, err_count);
    if (err_count == 0 && results_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for results");
    $display("status: fail");
    $finish;
  end

endmodule
